// ----- sv/fir_filter_int16_defines.svh -----
// Assertion macros shared by the FIR filter checker.
`ifndef FIR_FILTER_INT16_DEFINES_SVH
`define FIR_FILTER_INT16_DEFINES_SVH

// Checked on every clock edge outside of reset.
`define FIR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked on every clock edge, reset included.
`define FIR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ----- sv/fir_pkg.sv -----
// Shared types and constants of the FIR filter.
package fir_pkg;

  localparam int TAPS_DEF  = 32;
  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 18;
  localparam int IDX_W     = 5;
  localparam int CNT_W     = 6;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int FRAC_W    = 15;
  localparam int CNT_EXT_W = 9;
  localparam int IN_DATA_W = 40;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;

  localparam logic [CNT_W-1:0] TAP_COUNT_RST = 6'd32;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TAP    = 1'b1;

  localparam logic [CFG_AW-3:0] REG_TAP_COUNT = '0;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_DONE
  } fir_state_t;

  typedef struct packed {
    logic shift;
    logic rotate;
  } fir_ctl_t;

endpackage

// ----- sv/fir_cell.sv -----
// One cell of the delay line: a sample and its coefficient.
module fir_cell import fir_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  fir_ctl_t                   ctl,
  input  logic                       tap_we,
  input  logic signed [COEF_W-1:0]   tap_wdata,
  input  logic signed [SAMPLE_W-1:0] left_sample,
  input  logic signed [SAMPLE_W-1:0] right_sample,
  input  logic signed [COEF_W-1:0]   right_tap,
  output logic signed [SAMPLE_W-1:0] sample,
  output logic signed [COEF_W-1:0]   tap
);

  logic signed [SAMPLE_W-1:0] sample_r, sample_nxt;
  logic signed [COEF_W-1:0]   tap_r, tap_nxt;

  // A shift moves the delay line one place older; a rotation passes the
  // pair one place toward the head of the row.
  always_comb begin
    sample_nxt = sample_r;
    tap_nxt    = tap_r;
    if (ctl.shift) begin
      sample_nxt = left_sample;
    end else if (ctl.rotate) begin
      sample_nxt = right_sample;
    end
    if (ctl.rotate) begin
      tap_nxt = right_tap;
    end else if (tap_we) begin
      tap_nxt = tap_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r <= '0;
      tap_r    <= '0;
    end else begin
      sample_r <= sample_nxt;
      tap_r    <= tap_nxt;
    end
  end

  assign sample = sample_r;
  assign tap    = tap_r;

endmodule

// ----- sv/fir_mac.sv -----
// Multiply-accumulate unit with round-half-even and saturation.
module fir_mac import fir_pkg::*; #(
  parameter int TAPS = TAPS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       clear,
  input  logic                       issue,
  input  logic                       tap_live,
  input  logic signed [COEF_W-1:0]   tap,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic signed [SAMPLE_W-1:0] result,
  output logic                       sat
);

  localparam int ACC_W = PROD_W + $clog2(TAPS);
  localparam int FL_W  = ACC_W - FRAC_W;
  localparam logic signed [FL_W-1:0] MAX_V = FL_W'(32767);
  localparam logic signed [FL_W-1:0] MIN_V = FL_W'(-32768);
  localparam logic [FRAC_W-1:0]      HALF  = FRAC_W'(16384);

  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic                     prod_v_r, prod_v_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;

  logic signed [FL_W-1:0]   fl;
  logic [FRAC_W-1:0]        rem;
  logic                     up;
  logic signed [FL_W-1:0]   y;

  assign prod_nxt   = PROD_W'(tap) * PROD_W'(sample);
  assign prod_v_nxt = issue && tap_live;

  always_comb begin
    acc_nxt = acc_r;
    if (clear) begin
      acc_nxt = '0;
    end else if (prod_v_r) begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else begin
      prod_v_r <= prod_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  // Floor of the Q.15 sum, then a step up above one half, or at exactly
  // one half when the floor is odd.
  assign fl  = acc_r[ACC_W-1:FRAC_W];
  assign rem = acc_r[FRAC_W-1:0];
  assign up  = (rem > HALF) || ((rem == HALF) && fl[0]);
  assign y   = fl + FL_W'(up);

  always_comb begin
    sat    = 1'b0;
    result = y[SAMPLE_W-1:0];
    if (y > MAX_V) begin
      sat    = 1'b1;
      result = MAX_V[SAMPLE_W-1:0];
    end else if (y < MIN_V) begin
      sat    = 1'b1;
      result = MIN_V[SAMPLE_W-1:0];
    end
  end

endmodule

// ----- sv/fir_filter_int16.sv -----
// Top level of the direct-form FIR filter for signed 16-bit samples.
//
// Input words arrive on in_*: in_tuser selects a sample (0) or a coefficient
// write (1), in_tlast marks the last sample of a block and comes back as
// out_tlast. A coefficient write returns nothing.
// Each sample word yields one output word on out_*: the rounded (half to
// even), saturated sum in out_tdata and the saturation flag in out_tuser.
// The cfg_* port holds tap_count at byte address 0; taps at or above it
// count as zero, but a tap_count of zero acts as one.
// A sample is worked by rotating the row of TAPS cells past a single
// multiplier, one tap per cycle; each product is registered, then added
// into the accumulator, and the rounded sum is loaded into the output
// register. A new word is taken once the output word appears.
// Reset clears the delay line and all coefficients at once and sets
// tap_count to 32. While the receiver stalls, a finished word waits in the
// output register; a following sample is still taken and computed, and is
// held back at its end until the output register frees.
module fir_filter_int16 import fir_pkg::*; #(
  parameter int TAPS = TAPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // sample_in [15:0], tap_index [20:16], tap_value [38:21], zero [39]
  input  logic [IN_DATA_W-1:0] in_tdata,
  // cmd [0]
  input  logic                 in_tuser,
  input  logic                 in_tlast,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // sample_out [15:0]
  output logic [SAMPLE_W-1:0]  out_tdata,
  // saturated [0]
  output logic                 out_tuser,
  output logic                 out_tlast,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [CFG_AW-1:0]    cfg_paddr,
  input  logic [CFG_DW-1:0]    cfg_pwdata,
  output logic [CFG_DW-1:0]    cfg_prdata,
  output logic                 cfg_pready
);

  localparam int K_W = $clog2(TAPS);
  localparam logic [K_W-1:0]       K_LAST = K_W'(TAPS - 1);
  localparam logic [CNT_EXT_W-1:0] TAPS_X = CNT_EXT_W'(TAPS);

  fir_state_t state_r, state_nxt;
  logic [K_W-1:0]   k_r, k_nxt;
  logic [CNT_W-1:0] tap_count_r, tap_count_nxt;
  logic             last_r, last_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0] out_data_r, out_data_nxt;
  logic             out_sat_r, out_sat_nxt;
  logic             out_last_r, out_last_nxt;

  logic in_acc, is_sample, tap_wr, cfg_wr, can_load, out_load;
  logic rotate_en;
  fir_ctl_t ctl;
  logic [TAPS-1:0] tap_we;

  logic signed [SAMPLE_W-1:0] x_in;
  logic [IDX_W-1:0]           w_idx;
  logic signed [COEF_W-1:0]   w_val;

  logic signed [SAMPLE_W-1:0] smp [TAPS];
  logic signed [COEF_W-1:0]   cof [TAPS];

  logic [CNT_EXT_W-1:0] cnt_x, n_eff;
  logic                 tap_live;
  logic signed [SAMPLE_W-1:0] mac_result;
  logic                 mac_sat;

  assign x_in  = $signed(in_tdata[15:0]);
  assign w_idx = in_tdata[20:16];
  assign w_val = $signed(in_tdata[38:21]);

  assign in_acc    = in_tvalid && in_tready;
  assign is_sample = (in_tuser == CMD_SAMPLE);
  assign tap_wr    = in_acc && (in_tuser == CMD_TAP);
  assign can_load  = !out_valid_r || out_tready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && is_sample) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (k_r == K_LAST) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (can_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    in_tready = 1'b0;
    rotate_en = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE:  in_tready = 1'b1;
      S_RUN:   rotate_en = 1'b1;
      S_DRAIN: ;
      S_DONE:  out_load  = can_load;
      default: ;
    endcase
  end

  // Packed as {shift, rotate}.
  assign ctl = {in_acc && is_sample, rotate_en};

  always_comb begin
    k_nxt = k_r;
    if (ctl.rotate) begin
      k_nxt = (k_r == K_LAST) ? '0 : k_r + K_W'(1);
    end
  end

  assign cfg_wr        = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign tap_count_nxt = (cfg_wr && cfg_paddr[CFG_AW-1:2] == REG_TAP_COUNT)
                         ? cfg_pwdata[CNT_W-1:0] : tap_count_r;
  assign cfg_pready    = 1'b1;
  assign cfg_prdata    = (cfg_paddr[CFG_AW-1:2] == REG_TAP_COUNT)
                         ? CFG_DW'(tap_count_r) : '0;

  assign last_nxt = ctl.shift ? in_tlast : last_r;

  assign out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  assign out_data_nxt  = out_load ? mac_result : out_data_r;
  assign out_sat_nxt   = out_load ? mac_sat : out_sat_r;
  assign out_last_nxt  = out_load ? last_r : out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      tap_count_r <= TAP_COUNT_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      tap_count_r <= tap_count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r     <= last_nxt;
    out_data_r <= out_data_nxt;
    out_sat_r  <= out_sat_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;
  assign out_tlast  = out_last_r;

  // The cell at the head holds tap k in cycle k of a run; a full run of
  // TAPS rotations puts every pair back where it started.
  for (genvar i = 0; i < TAPS; i++) begin : g_cells
    assign tap_we[i] = tap_wr && (CNT_EXT_W'(w_idx) == CNT_EXT_W'(i));

    fir_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl          (ctl),
      .tap_we       (tap_we[i]),
      .tap_wdata    (w_val),
      .left_sample  ((i == 0) ? x_in : smp[(i + TAPS - 1) % TAPS]),
      .right_sample (smp[(i + 1) % TAPS]),
      .right_tap    (cof[(i + 1) % TAPS]),
      .sample       (smp[i]),
      .tap          (cof[i])
    );
  end

  // A tap count of zero acts as one, and one above TAPS as TAPS.
  assign cnt_x    = CNT_EXT_W'(tap_count_r);
  assign n_eff    = (cnt_x == '0) ? CNT_EXT_W'(1) : ((cnt_x > TAPS_X) ? TAPS_X : cnt_x);
  assign tap_live = (CNT_EXT_W'(k_r) < n_eff);

  fir_mac #(
    .TAPS (TAPS)
  ) u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (ctl.shift),
    .issue    (ctl.rotate),
    .tap_live (tap_live),
    .tap      (cof[0]),
    .sample   (smp[0]),
    .result   (mac_result),
    .sat      (mac_sat)
  );

endmodule

// ----- sv/fir_chk.sv -----
// Port checker for the FIR filter, bound to the top level.
`include "fir_filter_int16_defines.svh"

module fir_chk import fir_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_tvalid,
  input logic                 in_tready,
  input logic [IN_DATA_W-1:0] in_tdata,
  input logic                 in_tuser,
  input logic                 in_tlast,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [SAMPLE_W-1:0]  out_tdata,
  input logic                 out_tuser,
  input logic                 out_tlast
);

  // After reset the block is empty and takes a word at once.
  `FIR_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (!out_tvalid && in_tready), "not idle after reset")

  // A taken sample leaves the block busy, not ready for the next word.
  `FIR_ASSERT(a_sample_busy, (in_tvalid && in_tready && in_tuser == CMD_SAMPLE) |=> !in_tready, "ready after sample")

  // A coefficient write leaves the block ready for the next word.
  `FIR_ASSERT(a_tap_ready, (in_tvalid && in_tready && in_tuser == CMD_TAP) |=> in_tready, "busy after tap write")

  // A saturated word carries one of the two range limits.
  `FIR_ASSERT(a_sat_limit, (out_tvalid && out_tuser) |-> (out_tdata == 16'h7FFF || out_tdata == 16'h8000), "saturated value off limit")

  // A stalled output word holds.
  `FIR_ASSERT(a_out_hold, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast)), "stalled word changed")

endmodule

bind fir_filter_int16 fir_chk u_fir_chk (.*);
